@@ rtl/core/mecanum_joystick_wheel_mixer_defines.svh @@
// assertion macros for the mecanum wheel mixer
// used by the top level only, relies on clk_i and rst_ni in the including scope
`ifndef MECANUM_JOYSTICK_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_JOYSTICK_WHEEL_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
`define MJWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MJWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MJWM_ASSERT_SAME(lbl, ante, cons, msg)
`define MJWM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/mjwm_pkg.sv @@
// types and constants shared by the mecanum wheel mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mjwm_pkg;

  localparam int unsigned AXIS_W     = 8;
  localparam int unsigned GEAR_W     = 2;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CENTER_W   = 8;
  localparam int unsigned BAND_W     = 7;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 2;

  // signed dead band offset and its magnitude
  localparam int unsigned OFS_W      = 9;
  localparam int unsigned MAG_W      = 8;
  // band * magnitude, also the quotient width
  localparam int unsigned PROD_W     = 15;
  localparam int unsigned DIV_BITS   = 3;
  localparam int unsigned DIV_STAGES = PROD_W / DIV_BITS;
  // boosted axis, wheel sum, gear scale and scaled wheel
  localparam int unsigned BOOST_W    = 17;
  localparam int unsigned WHEEL_W    = 18;
  localparam int unsigned SCALE_W    = 7;
  localparam int unsigned SCALED_W   = 25;

  localparam int unsigned GEAR_SCALE     = 30;
  localparam int unsigned ROT_EXTRA_BAND = 5;
  // x / 3 == (x * 171) >> 9 for any 8 bit x
  localparam int unsigned DIV3_RECIP     = 171;
  localparam int unsigned DIV3_SHIFT     = 9;

  localparam logic [CENTER_W-1:0] CENTER_RST = 8'd128;
  localparam logic [BAND_W-1:0]   BAND_RST   = 7'd10;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_CENTER = 2'd0,
    CFG_DEAD_BAND    = 2'd1,
    CFG_SPEED_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CENTER_W-1:0] stick_center;
    logic [BAND_W-1:0]   dead_band;
    logic [LIMIT_W-1:0]  speed_limit;
  } cfg_t;

  typedef struct packed {
    logic [AXIS_W-1:0] strafe_axis;
    logic [AXIS_W-1:0] drive_axis;
    logic [AXIS_W-1:0] rotate_axis;
    logic [GEAR_W-1:0] speed_gear;
    logic              auto_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] front_left_speed;
    logic signed [SPEED_W-1:0] rear_left_speed;
    logic signed [SPEED_W-1:0] front_right_speed;
    logic signed [SPEED_W-1:0] rear_right_speed;
    logic                      speeds_valid;
    logic                      strafe_active;
    logic                      drive_active;
  } out_item_t;

  // fields that ride alongside the boost divider
  typedef struct packed {
    logic                    x_neg;
    logic                    y_neg;
    logic [MAG_W-1:0]        x_mag;
    logic [MAG_W-1:0]        y_mag;
    logic signed [OFS_W-1:0] rot;
    logic [GEAR_W-1:0]       gear;
    logic                    auto_mode;
    logic                    strafe_active;
    logic                    drive_active;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
  } front_out_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] quot_x;
    logic [PROD_W-1:0] quot_y;
  } quot_t;

endpackage

`default_nettype wire

@@ rtl/core/mecanum_joystick_wheel_mixer.sv @@
// top level of the mecanum wheel mixer: config registers and the three pipeline sections
// depends on mjwm_pkg, mjwm_front, mjwm_div, mjwm_mix and the assertion macro header
//
//   port group    dir  handshake               payload
//   in            in   in_valid_i / in_stall_o  in_item_i  (mjwm_pkg::in_item_t)
//   out           out  out_valid_o/out_stall_i  out_item_o (mjwm_pkg::out_item_t)
//   cfg           in   cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// one beat per cycle while out_stall_i is low, through 11 register
// stages, 2 front, 5 divider (3 quotient bits each, set by the 15 bit boost divide)
// and 4 mix, the last of which is the output register. each stage moves on when it
// is empty or the next one moves, so bubbles close up under a stall and in_stall_o
// only rises once every stage is full. reset clears the valid bits and loads
// center 128, band 10, limit 3000
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_joystick_wheel_mixer_defines.svh"

module mecanum_joystick_wheel_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mjwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mjwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mjwm_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mjwm_pkg::out_item_t             out_item_o
);
  import mjwm_pkg::*;

  cfg_t       cfg_q;
  logic       front_valid, front_stall;
  front_out_t front_data;
  logic       div_valid, div_stall;
  quot_t      div_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_center <= CENTER_RST;
      cfg_q.dead_band    <= BAND_RST;
      cfg_q.speed_limit  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STICK_CENTER: cfg_q.stick_center <= cfg_wdata_i[CENTER_W-1:0];
        CFG_DEAD_BAND:    cfg_q.dead_band    <= cfg_wdata_i[BAND_W-1:0];
        CFG_SPEED_LIMIT:  cfg_q.speed_limit  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  mjwm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item_i),
    .valid_o (front_valid),
    .stall_i (front_stall),
    .data_o  (front_data)
  );

  mjwm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (cfg_q.stick_center),
    .valid_i   (front_valid),
    .stall_o   (front_stall),
    .data_i    (front_data),
    .valid_o   (div_valid),
    .stall_i   (div_stall),
    .data_o    (div_data)
  );

  mjwm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (div_valid),
    .stall_o (div_stall),
    .data_i  (div_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

  // a free sink always lets the pipe take a new beat
  `MJWM_ASSERT_SAME(a_no_stall_when_sink_free, !out_stall_i, !in_stall_o, "input stalled with free sink")

  `MJWM_ASSERT_SAME(a_auto_blanks_speeds, out_valid_o && !out_item_o.speeds_valid, out_item_o.front_left_speed == '0 && out_item_o.rear_left_speed == '0 && out_item_o.front_right_speed == '0 && out_item_o.rear_right_speed == '0, "auto mode beat carries speeds")

  `MJWM_ASSERT_SAME(a_speed_within_limit, out_valid_o && out_item_o.speeds_valid, out_item_o.front_left_speed <= $signed({1'b0, cfg_q.speed_limit}) && out_item_o.front_left_speed >= -$signed({1'b0, cfg_q.speed_limit}) && out_item_o.rear_right_speed <= $signed({1'b0, cfg_q.speed_limit}) && out_item_o.rear_right_speed >= -$signed({1'b0, cfg_q.speed_limit}), "wheel speed beyond limit")

  `MJWM_ASSERT_NEXT(a_limit_write_lands, cfg_we_i && cfg_idx_i == CFG_SPEED_LIMIT, cfg_q.speed_limit == $past(cfg_wdata_i[LIMIT_W-1:0]), "speed limit write lost")

endmodule

`default_nettype wire

@@ rtl/core/mjwm_front.sv @@
// front end: dead band offsets, boost products and rotation divide
// depends on mjwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mjwm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mjwm_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  mjwm_pkg::in_item_t   item_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output mjwm_pkg::front_out_t data_o
);
  import mjwm_pkg::*;

  localparam int unsigned EDGE_W = 11;
  localparam int unsigned RMUL_W = 17;

  typedef struct packed {
    logic                    active;
    logic signed [OFS_W-1:0] ofs;
  } band_res_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] x_ofs;
    logic signed [OFS_W-1:0] y_ofs;
    logic signed [OFS_W-1:0] r_ofs;
    logic [GEAR_W-1:0]       gear;
    logic                    auto_mode;
    logic                    strafe_active;
    logic                    drive_active;
  } ofs_t;

  function automatic band_res_t band_offset(input logic [AXIS_W-1:0] v,
                                            input logic [AXIS_W-1:0] c,
                                            input logic [AXIS_W-1:0] band);
    logic signed [EDGE_W-1:0] vs;
    logic signed [EDGE_W-1:0] lo;
    logic signed [EDGE_W-1:0] hi;
    logic signed [EDGE_W-1:0] diff;
    band_res_t                res;
    vs = $signed({{(EDGE_W-AXIS_W){1'b0}}, v});
    lo = $signed({{(EDGE_W-AXIS_W){1'b0}}, c}) - $signed({{(EDGE_W-AXIS_W){1'b0}}, band});
    hi = $signed({{(EDGE_W-AXIS_W){1'b0}}, c}) + $signed({{(EDGE_W-AXIS_W){1'b0}}, band});
    if (vs < lo) begin
      res.active = 1'b1;
      diff       = vs - lo;
    end else if (vs < hi) begin
      res.active = 1'b0;
      diff       = '0;
    end else begin
      res.active = 1'b1;
      diff       = vs - hi;
    end
    res.ofs = diff[OFS_W-1:0];
    return res;
  endfunction

  logic adv1, adv2;
  logic s1_v_q, s2_v_q;
  ofs_t s1_d, s1_q;
  front_out_t s2_d, s2_q;

  band_res_t band_x, band_y, band_r;
  logic [AXIS_W-1:0] band_l, band_rot;

  logic signed [OFS_W-1:0] x_abs, y_abs, r_abs;
  logic [MAG_W-1:0]        r_mag, r_quot;
  logic [RMUL_W-1:0]       r_mul;

  assign adv2    = !s2_v_q || !stall_i;
  assign adv1    = !s1_v_q || adv2;
  assign stall_o = !adv1;
  assign valid_o = s2_v_q;
  assign data_o  = s2_q;

  // stage 1: dead band
  always_comb begin
    band_l   = {1'b0, cfg_i.dead_band};
    band_rot = band_l + AXIS_W'(ROT_EXTRA_BAND);
    band_x   = band_offset(item_i.strafe_axis, cfg_i.stick_center, band_l);
    band_y   = band_offset(item_i.drive_axis, cfg_i.stick_center, band_l);
    band_r   = band_offset(item_i.rotate_axis, cfg_i.stick_center, band_rot);
    s1_d.x_ofs         = band_x.ofs;
    s1_d.y_ofs         = band_y.ofs;
    s1_d.r_ofs         = band_r.ofs;
    s1_d.gear          = item_i.speed_gear;
    s1_d.auto_mode     = item_i.auto_mode;
    s1_d.strafe_active = band_x.active;
    s1_d.drive_active  = band_y.active;
  end

  // stage 2: magnitudes, boost numerators, rotation over (4 - gear)
  always_comb begin
    x_abs  = s1_q.x_ofs[OFS_W-1] ? -s1_q.x_ofs : s1_q.x_ofs;
    y_abs  = s1_q.y_ofs[OFS_W-1] ? -s1_q.y_ofs : s1_q.y_ofs;
    r_abs  = s1_q.r_ofs[OFS_W-1] ? -s1_q.r_ofs : s1_q.r_ofs;
    r_mag  = r_abs[MAG_W-1:0];
    r_mul  = {{(RMUL_W-MAG_W){1'b0}}, r_mag} * RMUL_W'(DIV3_RECIP);
    case (s1_q.gear)
      2'd0:    r_quot = r_mag >> 2;
      2'd1:    r_quot = r_mul[DIV3_SHIFT +: MAG_W];
      2'd2:    r_quot = r_mag >> 1;
      default: r_quot = r_mag;
    endcase
    s2_d.side.x_neg = s1_q.x_ofs[OFS_W-1];
    s2_d.side.y_neg = s1_q.y_ofs[OFS_W-1];
    s2_d.side.x_mag = x_abs[MAG_W-1:0];
    s2_d.side.y_mag = y_abs[MAG_W-1:0];
    s2_d.side.rot   = s1_q.r_ofs[OFS_W-1] ? -$signed({1'b0, r_quot})
                                          : $signed({1'b0, r_quot});
    s2_d.side.gear          = s1_q.gear;
    s2_d.side.auto_mode     = s1_q.auto_mode;
    s2_d.side.strafe_active = s1_q.strafe_active;
    s2_d.side.drive_active  = s1_q.drive_active;
    s2_d.prod_x = {{(PROD_W-BAND_W){1'b0}}, cfg_i.dead_band}
                * {{(PROD_W-MAG_W){1'b0}}, x_abs[MAG_W-1:0]};
    s2_d.prod_y = {{(PROD_W-BAND_W){1'b0}}, cfg_i.dead_band}
                * {{(PROD_W-MAG_W){1'b0}}, y_abs[MAG_W-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_q <= valid_i;
      end
      if (adv2) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q <= s1_d;
    end
    if (adv2) begin
      s2_q <= s2_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mjwm_div.sv @@
// pipelined restoring divider for the two boost terms, three quotient bits per stage
// depends on mjwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mjwm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mjwm_pkg::CENTER_W-1:0] divisor_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  mjwm_pkg::front_out_t          data_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output mjwm_pkg::quot_t               data_o
);
  import mjwm_pkg::*;

  typedef struct packed {
    logic [CENTER_W-1:0] rem;
    logic [PROD_W-1:0]   acc;
  } div_res_t;

  // acc holds the dividend bits still to go on top and the quotient bits below
  function automatic div_res_t div_steps(input logic [CENTER_W-1:0] rem,
                                         input logic [PROD_W-1:0]   acc,
                                         input logic [CENTER_W-1:0] dvs);
    logic [CENTER_W:0]   trial;
    logic [CENTER_W:0]   diff;
    logic [CENTER_W-1:0] r;
    logic [PROD_W-1:0]   a;
    div_res_t            res;
    r = rem;
    a = acc;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r, a[PROD_W-1]};
      a     = {a[PROD_W-2:0], 1'b0};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
        r    = diff[CENTER_W-1:0];
        a[0] = 1'b1;
      end else begin
        r = trial[CENTER_W-1:0];
      end
    end
    res.rem = r;
    res.acc = a;
    return res;
  endfunction

  logic [DIV_STAGES:0]   adv;
  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES-1:0] v_src;

  logic [CENTER_W-1:0] rem_x_q   [DIV_STAGES];
  logic [CENTER_W-1:0] rem_y_q   [DIV_STAGES];
  logic [PROD_W-1:0]   acc_x_q   [DIV_STAGES];
  logic [PROD_W-1:0]   acc_y_q   [DIV_STAGES];
  side_t               side_q    [DIV_STAGES];
  logic [CENTER_W-1:0] rem_x_src [DIV_STAGES];
  logic [CENTER_W-1:0] rem_y_src [DIV_STAGES];
  logic [PROD_W-1:0]   acc_x_src [DIV_STAGES];
  logic [PROD_W-1:0]   acc_y_src [DIV_STAGES];
  side_t               side_src  [DIV_STAGES];
  div_res_t            step_x    [DIV_STAGES];
  div_res_t            step_y    [DIV_STAGES];

  always_comb begin
    adv[DIV_STAGES] = !stall_i;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end

    v_src[0]     = valid_i;
    rem_x_src[0] = '0;
    rem_y_src[0] = '0;
    acc_x_src[0] = data_i.prod_x;
    acc_y_src[0] = data_i.prod_y;
    side_src[0]  = data_i.side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      v_src[s]     = v_q[s-1];
      rem_x_src[s] = rem_x_q[s-1];
      rem_y_src[s] = rem_y_q[s-1];
      acc_x_src[s] = acc_x_q[s-1];
      acc_y_src[s] = acc_y_q[s-1];
      side_src[s]  = side_q[s-1];
    end

    for (int s = 0; s < DIV_STAGES; s++) begin
      step_x[s] = div_steps(rem_x_src[s], acc_x_src[s], divisor_i);
      step_y[s] = div_steps(rem_y_src[s], acc_y_src[s], divisor_i);
    end
  end

  assign stall_o       = !adv[0];
  assign valid_o       = v_q[DIV_STAGES-1];
  assign data_o.side   = side_q[DIV_STAGES-1];
  assign data_o.quot_x = acc_x_q[DIV_STAGES-1];
  assign data_o.quot_y = acc_y_q[DIV_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (adv[s]) begin
        rem_x_q[s] <= step_x[s].rem;
        rem_y_q[s] <= step_y[s].rem;
        acc_x_q[s] <= step_x[s].acc;
        acc_y_q[s] <= step_y[s].acc;
        side_q[s]  <= side_src[s];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mjwm_mix.sv @@
// back end: boost add, wheel mixing, gear scaling, saturation and auto mode blanking
// depends on mjwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mjwm_mix (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mjwm_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  output logic                stall_o,
  input  mjwm_pkg::quot_t     data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output mjwm_pkg::out_item_t item_o
);
  import mjwm_pkg::*;

  localparam int unsigned NUM_WHEELS = 4;
  localparam int unsigned BMAG_W     = BOOST_W - 1;

  typedef struct packed {
    logic signed [BOOST_W-1:0] bx;
    logic signed [BOOST_W-1:0] by;
    logic signed [OFS_W-1:0]   rot;
    logic [GEAR_W-1:0]         gear;
    logic                      auto_mode;
    logic                      strafe_active;
    logic                      drive_active;
  } boost_t;

  typedef struct packed {
    logic       auto_mode;
    logic       strafe_active;
    logic       drive_active;
  } flags_t;

  logic adv1, adv2, adv3, adv4;
  logic v1_q, v2_q, v3_q, v4_q;

  boost_t b_d, b_q;
  logic [BMAG_W-1:0] mag_x, mag_y;

  logic signed [WHEEL_W-1:0] ex, ey, er;
  logic signed [WHEEL_W-1:0] wheel_d [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] wheel_q [NUM_WHEELS];
  logic [SCALE_W-1:0]        scale_d, scale_q;
  flags_t                    f2_q, f3_q;

  logic signed [SCALED_W-1:0] scaled_d [NUM_WHEELS];
  logic signed [SCALED_W-1:0] scaled_q [NUM_WHEELS];
  logic signed [SCALED_W-1:0] lim_pos, lim_neg;
  logic signed [SCALED_W-1:0] sat     [NUM_WHEELS];
  out_item_t                  item_d, item_q;

  assign adv4    = !v4_q || !stall_i;
  assign adv3    = !v3_q || adv4;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign stall_o = !adv1;
  assign valid_o = v4_q;
  assign item_o  = item_q;

  // stage 1: |v| + band*|v|/center, sign put back; a zero center adds nothing
  always_comb begin
    mag_x = {{(BMAG_W-MAG_W){1'b0}}, data_i.side.x_mag}
          + ((cfg_i.stick_center == '0) ? '0 : {{(BMAG_W-PROD_W){1'b0}}, data_i.quot_x});
    mag_y = {{(BMAG_W-MAG_W){1'b0}}, data_i.side.y_mag}
          + ((cfg_i.stick_center == '0) ? '0 : {{(BMAG_W-PROD_W){1'b0}}, data_i.quot_y});
    b_d.bx = data_i.side.x_neg ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    b_d.by = data_i.side.y_neg ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    b_d.rot           = data_i.side.rot;
    b_d.gear          = data_i.side.gear;
    b_d.auto_mode     = data_i.side.auto_mode;
    b_d.strafe_active = data_i.side.strafe_active;
    b_d.drive_active  = data_i.side.drive_active;
  end

  // stage 2: mecanum mix, wheel order fl, rl, fr, rr
  always_comb begin
    ex = {{(WHEEL_W-BOOST_W){b_q.bx[BOOST_W-1]}}, b_q.bx};
    ey = {{(WHEEL_W-BOOST_W){b_q.by[BOOST_W-1]}}, b_q.by};
    er = {{(WHEEL_W-OFS_W){b_q.rot[OFS_W-1]}}, b_q.rot};
    wheel_d[0] = -ey - ex - er;
    wheel_d[1] = -ey + ex - er;
    wheel_d[2] = ey - ex - er;
    wheel_d[3] = ey + ex - er;
    scale_d = ({{(SCALE_W-GEAR_W){1'b0}}, b_q.gear} + SCALE_W'(1)) * SCALE_W'(GEAR_SCALE);
  end

  // stage 3: gear scaling
  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      scaled_d[w] = {{(SCALED_W-WHEEL_W){wheel_q[w][WHEEL_W-1]}}, wheel_q[w]}
                  * $signed({{(SCALED_W-SCALE_W){1'b0}}, scale_q});
    end
  end

  // stage 4: clamp to +/- limit, auto mode blanks the speeds
  always_comb begin
    lim_pos = $signed({{(SCALED_W-LIMIT_W){1'b0}}, cfg_i.speed_limit});
    lim_neg = -lim_pos;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (scaled_q[w] >= lim_pos) begin
        sat[w] = lim_pos;
      end else if (scaled_q[w] <= lim_neg) begin
        sat[w] = lim_neg;
      end else begin
        sat[w] = scaled_q[w];
      end
    end
    item_d.front_left_speed  = f3_q.auto_mode ? '0 : sat[0][SPEED_W-1:0];
    item_d.rear_left_speed   = f3_q.auto_mode ? '0 : sat[1][SPEED_W-1:0];
    item_d.front_right_speed = f3_q.auto_mode ? '0 : sat[2][SPEED_W-1:0];
    item_d.rear_right_speed  = f3_q.auto_mode ? '0 : sat[3][SPEED_W-1:0];
    item_d.speeds_valid      = !f3_q.auto_mode;
    item_d.strafe_active     = f3_q.strafe_active;
    item_d.drive_active      = f3_q.drive_active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      b_q <= b_d;
    end
    if (adv2) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        wheel_q[w] <= wheel_d[w];
      end
      scale_q            <= scale_d;
      f2_q.auto_mode     <= b_q.auto_mode;
      f2_q.strafe_active <= b_q.strafe_active;
      f2_q.drive_active  <= b_q.drive_active;
    end
    if (adv3) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        scaled_q[w] <= scaled_d[w];
      end
      f3_q <= f2_q;
    end
    if (adv4) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire
